FILE: sv/versioned_key_value_floor_lookup_assert.svh
// Assertion macros used by the checker file of the floor lookup block.
`ifndef VERSIONED_KEY_VALUE_FLOOR_LOOKUP_ASSERT_SVH
`define VERSIONED_KEY_VALUE_FLOOR_LOOKUP_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define VKVFL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check written as an implication from a trigger to a consequence.
`define VKVFL_ASSERT_IMPL(label, trig, cons, msg) \
  `VKVFL_ASSERT(label, (trig) |-> (cons), msg)

`endif

FILE: sv/vkvfl_pkg.sv
// Package with the constants, codes and types of the floor lookup block.
package vkvfl_pkg;

  localparam int KEY_COUNT       = 16;
  localparam int ENTRIES_PER_KEY = 64;
  localparam int TIME_BITS       = 24;
  localparam int VALUE_BITS      = 32;
  localparam int STATUS_BITS     = 3;

  localparam int KEY_BITS  = $clog2(KEY_COUNT);
  localparam int IDX_BITS  = $clog2(ENTRIES_PER_KEY);
  localparam int CNT_BITS  = $clog2(ENTRIES_PER_KEY + 1);
  localparam int ADDR_BITS = KEY_BITS + IDX_BITS;
  localparam int RAM_DEPTH = KEY_COUNT * ENTRIES_PER_KEY;
  localparam int RAM_WIDTH = TIME_BITS + VALUE_BITS;

  localparam logic MODE_SET = 1'b0;
  localparam logic MODE_GET = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_STORED         = 3'd0,
    ST_FULL           = 3'd1,
    ST_NOT_INCREASING = 3'd2,
    ST_FOUND          = 3'd3,
    ST_NOT_FOUND      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_GET_CMP,
    S_SET_CHK,
    S_RESULT
  } state_t;

endpackage

FILE: sv/vkvfl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module vkvfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/versioned_key_value_floor_lookup.sv
// Top level of the versioned key/value floor lookup block.
//
// Each of 16 keys owns a history of up to 64 (timestamp, value) entries. An item
// on the in_ channel is a set (in_tuser = 0), which appends an entry, or a get
// (in_tuser = 1), which returns the value of the newest entry at or below the
// query time. Every item gives one result item on the out_ channel: out_tuser
// carries the status and out_tdata the value, zero unless the status is found.
// A set fails with a status when the history is full or its time does not rise.
// The block takes one item at a time. After acceptance it runs S_START and then
// S_RESULT for a set to an empty or full history, adds S_SET_CHK, which reads
// the newest entry for the ordering check, for any other set, and for a get
// runs S_START, one S_GET_CMP per search step, at most ceil(log2(n+1)) steps
// for n entries, and S_RESULT. in_tready returns as the result enters the output
// register; the entry RAM gives one timestamp per cycle to the compare.
// Reset clears all per-key counts, so every history starts empty; the entry RAM
// needs no clearing. When the receiver stalls, the result waits in the output
// register and the next finished result waits in the block until it frees up.
module versioned_key_value_floor_lookup
  import vkvfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // key_id [3:0], value_word [35:4], timestamp [59:36]
  input  logic [0:0]  in_tuser,  // mode [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // result_value [31:0]
  output logic [2:0]  out_tuser  // status [2:0]
);

  state_t state_r, state_nxt;

  // Captured item.
  logic                  mode_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [TIME_BITS-1:0]  ts_r;

  // Per-key fill counts, cleared at reset.
  logic [CNT_BITS-1:0] count_r [KEY_COUNT];
  logic                cnt_inc;
  logic [CNT_BITS-1:0] cnt_key;

  // Binary search window and best match so far.
  logic [CNT_BITS-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_BITS-1:0]   mid_r, mid_nxt;
  logic                  found_r, found_nxt;
  logic [VALUE_BITS-1:0] fval_r, fval_nxt;

  // Finished result waiting for the output register.
  status_t               res_status_r, res_status_nxt;
  logic [VALUE_BITS-1:0] res_value_r, res_value_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;

  // Entry RAM: timestamp in the upper bits, value in the lower bits.
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
  logic [RAM_WIDTH-1:0]  wr_data, rd_data;
  logic [TIME_BITS-1:0]  rd_time;
  logic [VALUE_BITS-1:0] rd_val;

  logic                  in_acc;
  logic                  out_free;
  logic                  hit;
  logic                  set_bad;
  logic                  full;
  logic [CNT_BITS-1:0]   srch_lo, srch_hi;
  logic                  srch_more;
  logic [CNT_BITS:0]     mid_sum;
  logic [IDX_BITS-1:0]   last_idx;

  vkvfl_ram #(
    .WIDTH (RAM_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  assign cnt_key  = count_r[key_r];
  assign full     = (cnt_key == CNT_BITS'(ENTRIES_PER_KEY));
  assign last_idx = IDX_BITS'(cnt_key - CNT_BITS'(1));

  assign rd_time = rd_data[RAM_WIDTH-1 -: TIME_BITS];
  assign rd_val  = rd_data[VALUE_BITS-1:0];

  // The RAM word read last cycle is the probe at mid_r (get) or the newest
  // entry of the key (set).
  assign hit     = (rd_time <= ts_r);
  assign set_bad = (ts_r <= rd_time);

  // Search window for the probe issued this cycle: the full history when the
  // search starts, the narrowed window after each compare.
  always_comb begin
    if (state_r == S_GET_CMP) begin
      srch_lo = hit ? (CNT_BITS'(mid_r) + CNT_BITS'(1)) : lo_r;
      srch_hi = hit ? hi_r : CNT_BITS'(mid_r);
    end else begin
      srch_lo = '0;
      srch_hi = cnt_key;
    end
  end

  assign srch_more = (srch_lo < srch_hi);
  assign mid_sum   = {1'b0, srch_lo} + {1'b0, srch_hi};
  assign mid_nxt   = mid_sum[IDX_BITS:1];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (mode_r == MODE_GET) begin
          state_nxt = srch_more ? S_GET_CMP : S_RESULT;
        end else if (full || (cnt_key == '0)) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_SET_CHK;
        end
      end
      S_GET_CMP: begin
        state_nxt = srch_more ? S_GET_CMP : S_RESULT;
      end
      S_SET_CHK: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control per state.
  always_comb begin
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    found_nxt      = found_r;
    fval_nxt       = fval_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    wr_en          = 1'b0;
    cnt_inc        = 1'b0;
    wr_addr        = {key_r, IDX_BITS'(cnt_key)};
    wr_data        = {ts_r, val_r};
    rd_addr        = {key_r, mid_nxt};
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;

    unique case (state_r)
      S_IDLE: begin
      end
      S_START: begin
        if (mode_r == MODE_GET) begin
          lo_nxt    = srch_lo;
          hi_nxt    = srch_hi;
          found_nxt = 1'b0;
          fval_nxt  = '0;
          if (!srch_more) begin
            res_status_nxt = ST_NOT_FOUND;
            res_value_nxt  = '0;
          end
        end else begin
          // Fetch the newest entry for the ordering check.
          rd_addr = {key_r, last_idx};
          if (full) begin
            res_status_nxt = ST_FULL;
            res_value_nxt  = '0;
          end else if (cnt_key == '0) begin
            wr_en          = 1'b1;
            cnt_inc        = 1'b1;
            res_status_nxt = ST_STORED;
            res_value_nxt  = '0;
          end
        end
      end
      S_GET_CMP: begin
        lo_nxt = srch_lo;
        hi_nxt = srch_hi;
        if (hit) begin
          found_nxt = 1'b1;
          fval_nxt  = rd_val;
        end
        if (!srch_more) begin
          res_status_nxt = found_nxt ? ST_FOUND : ST_NOT_FOUND;
          res_value_nxt  = found_nxt ? fval_nxt : '0;
        end
      end
      S_SET_CHK: begin
        res_value_nxt = '0;
        if (set_bad) begin
          res_status_nxt = ST_NOT_INCREASING;
        end else begin
          wr_en          = 1'b1;
          cnt_inc        = 1'b1;
          res_status_nxt = ST_STORED;
        end
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase

    if ((state_r == S_RESULT) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_value_nxt  = res_value_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < KEY_COUNT; k++) begin
        count_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cnt_inc) begin
        count_r[key_r] <= cnt_key + CNT_BITS'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_tuser[0];
      key_r  <= in_tdata[KEY_BITS-1:0];
      val_r  <= in_tdata[KEY_BITS +: VALUE_BITS];
      ts_r   <= in_tdata[KEY_BITS + VALUE_BITS +: TIME_BITS];
    end
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    found_r      <= found_nxt;
    fval_r       <= fval_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

endmodule

FILE: sv/vkvfl_checker.sv
// Port-level checker for the floor lookup block, bound to the top level.
`include "versioned_key_value_floor_lookup_assert.svh"

module vkvfl_checker
  import vkvfl_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // A result stalled by the receiver keeps its contents.
  `VKVFL_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // Only a found result carries a value.
  `VKVFL_ASSERT_IMPL(a_value_zero, out_tvalid && (out_tuser != ST_FOUND), out_tdata == '0, "value on a result that is not found")

  // The block works on one item at a time.
  `VKVFL_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "second item taken while busy")

endmodule

bind versioned_key_value_floor_lookup vkvfl_checker u_vkvfl_checker (.*);
